@@ rtl/core/ppmhp_pkg.sv @@
// Shared types, widths and codes for the PPM/PGM header parser.
package ppmhp_pkg;

   // Field widths fixed by the interface.
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 13;
   localparam int STATUS_W = 3;
   localparam int FIELD_W  = 16;
   localparam int BPP_W    = 2;

   // Default storage width of the parsed dimensions.
   localparam int DIM_BITS_DEF = 16;

   // Header byte limit after reset.
   localparam logic [COUNT_W-1:0] MAX_HDR_RESET = 13'd256;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_MAGIC  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_MAXVAL = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd4;

   // Characters the parser looks for.
   localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
   localparam logic [BYTE_W-1:0] CH_5     = 8'h35;
   localparam logic [BYTE_W-1:0] CH_6     = 8'h36;
   localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
   localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
   localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

   // Required maxval.
   localparam int MAXVAL_REQ = 255;

   // Pixel sizes for the two magic digits.
   localparam logic [BPP_W-1:0] BPP_GRAY = 2'd1;
   localparam logic [BPP_W-1:0] BPP_RGB  = 2'd3;

   // One input word.
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              first_byte;
      logic              last_byte;
   } req_item_type;

   // One result word.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0]  width;
      logic [FIELD_W-1:0]  height;
      logic [BPP_W-1:0]    bytes_per_pixel;
      logic [COUNT_W-1:0]  header_len;
   } rsp_item_type;

endpackage

@@ rtl/core/ppmhp_in_stage.sv @@
// Input register that holds one accepted word until the parser takes it.
module ppmhp_in_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ppmhp_pkg::req_item_type req_item,
   input  logic                    advance,
   output logic                    item_valid,
   output ppmhp_pkg::req_item_type item
);
   import ppmhp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   logic         take;
   req_item_type item_ff;

   // A held word blocks the port until the parser consumes it.
   assign req_stall = valid_ff & ~advance;
   assign take      = req_valid & ~req_stall;
   assign valid_in  = take | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads only on acceptance.
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/core/ppmhp_parse.sv @@
// Header parsing state and the per-byte next-state logic.
module ppmhp_parse #(
   parameter int DIM_BITS = ppmhp_pkg::DIM_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  ppmhp_pkg::req_item_type           item,
   input  logic                              out_ready,
   input  logic [ppmhp_pkg::COUNT_W-1:0]     max_bytes,
   output logic                              advance,
   output logic                              emit,
   output ppmhp_pkg::rsp_item_type           result
);
   import ppmhp_pkg::*;

   localparam int ACC_W = DIM_BITS + 4;

   // Parse phases.
   localparam logic [3:0] PH_MAGIC_P  = 4'd0;
   localparam logic [3:0] PH_MAGIC_D  = 4'd1;
   localparam logic [3:0] PH_MAGIC_LF = 4'd2;
   localparam logic [3:0] PH_W_SKIP   = 4'd3;
   localparam logic [3:0] PH_W_START  = 4'd4;
   localparam logic [3:0] PH_W_DIGIT  = 4'd5;
   localparam logic [3:0] PH_H_SKIP   = 4'd6;
   localparam logic [3:0] PH_H_START  = 4'd7;
   localparam logic [3:0] PH_H_DIGIT  = 4'd8;
   localparam logic [3:0] PH_M_SKIP   = 4'd9;
   localparam logic [3:0] PH_M_START  = 4'd10;
   localparam logic [3:0] PH_M_DIGIT  = 4'd11;
   localparam logic [3:0] PH_SEEK_LF  = 4'd12;
   localparam logic [3:0] PH_DONE     = 4'd13;

   logic [3:0]          phase_ff, phase_in, cur_phase;
   logic [COUNT_W-1:0]  count_ff, count_in, cur_count, count_inc;
   logic [DIM_BITS-1:0] acc_ff, acc_in, cur_acc;
   logic                line_ff, line_in, cur_line;
   logic                cmt_ff, cmt_in, cur_cmt;
   logic [DIM_BITS-1:0] w_ff, w_in, cur_w;
   logic [DIM_BITS-1:0] h_ff, h_in, cur_h;
   logic [BPP_W-1:0]    bpp_ff, bpp_in, cur_bpp;
   logic                ovf_ff, ovf_in, cur_ovf;

   logic [BYTE_W-1:0]   b;
   logic                is_lf, is_hash, is_blank, is_num, active;
   logic [ACC_W-1:0]    acc_ext, acc_prod;
   logic                acc_big;
   logic [DIM_BITS-1:0] acc_sat, acc_first;
   logic                st_vld;
   logic [STATUS_W-1:0] st_code;
   logic [COUNT_W-1:0]  hlen;

   // A first byte sees the restart values instead of the stored state.
   always_comb begin
      if (item.first_byte) begin
         cur_phase = PH_MAGIC_P;
         cur_count = '0;
         cur_acc   = '0;
         cur_line  = 1'b1;
         cur_cmt   = 1'b0;
         cur_w     = '0;
         cur_h     = '0;
         cur_bpp   = '0;
         cur_ovf   = 1'b0;
      end else begin
         cur_phase = phase_ff;
         cur_count = count_ff;
         cur_acc   = acc_ff;
         cur_line  = line_ff;
         cur_cmt   = cmt_ff;
         cur_w     = w_ff;
         cur_h     = h_ff;
         cur_bpp   = bpp_ff;
         cur_ovf   = ovf_ff;
      end
   end

   // Byte classes.
   assign b        = item.data_byte;
   assign is_lf    = (b == CH_LF);
   assign is_hash  = (b == CH_HASH);
   assign is_blank = is_hash | is_lf | (b == CH_SPACE) | (b == CH_TAB) | (b == CH_CR);
   assign is_num   = (b >= CH_0) && (b <= CH_9);
   assign active   = (cur_phase != PH_DONE);

   // Saturating byte count.
   assign count_inc = (cur_count != '1) ? cur_count + 1'b1 : cur_count;

   // Decimal accumulate: acc * 10 + digit, saturating at the dimension limit.
   assign acc_ext   = ACC_W'(cur_acc);
   assign acc_prod  = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(b[3:0]);
   assign acc_big   = |acc_prod[ACC_W-1:DIM_BITS];
   assign acc_sat   = acc_big ? '1 : acc_prod[DIM_BITS-1:0];
   assign acc_first = DIM_BITS'(b[3:0]);

   // Next state for one byte, with all re-dispatches folded in.
   always_comb begin
      phase_in = cur_phase;
      count_in = active ? count_inc : cur_count;
      acc_in   = cur_acc;
      line_in  = cur_line;
      cmt_in   = cur_cmt;
      w_in     = cur_w;
      h_in     = cur_h;
      bpp_in   = cur_bpp;
      ovf_in   = cur_ovf;
      st_vld   = 1'b0;
      st_code  = ST_OK;
      hlen     = '0;

      unique case (cur_phase)
         PH_MAGIC_P: begin
            if (b == CH_P) begin
               phase_in = PH_MAGIC_D;
            end else begin
               st_vld  = 1'b1;
               st_code = ST_BAD_MAGIC;
            end
         end
         PH_MAGIC_D: begin
            if (b == CH_5) begin
               bpp_in   = BPP_GRAY;
               phase_in = PH_MAGIC_LF;
            end else if (b == CH_6) begin
               bpp_in   = BPP_RGB;
               phase_in = PH_MAGIC_LF;
            end else begin
               st_vld  = 1'b1;
               st_code = ST_BAD_MAGIC;
            end
         end
         PH_MAGIC_LF: begin
            if (is_lf) begin
               phase_in = PH_W_SKIP;
               line_in  = 1'b1;
               cmt_in   = 1'b0;
            end else begin
               st_vld  = 1'b1;
               st_code = ST_BAD_MAGIC;
            end
         end
         PH_W_SKIP, PH_H_SKIP, PH_M_SKIP: begin
            // Whitespace and comment lines; a digit starts a value, any other byte moves to the start phase.
            if (cur_cmt) begin
               if (is_lf) begin
                  cmt_in  = 1'b0;
                  line_in = 1'b1;
               end
            end else if (is_blank) begin
               if (cur_line && is_hash) begin
                  cmt_in = 1'b1;
               end else begin
                  line_in = is_lf;
               end
            end else if (is_num) begin
               acc_in   = acc_first;
               phase_in = cur_phase + 4'd2;
            end else begin
               phase_in = cur_phase + 4'd1;
            end
         end
         PH_W_START, PH_H_START, PH_M_START: begin
            if (is_num) begin
               acc_in   = acc_first;
               phase_in = cur_phase + 4'd1;
            end
         end
         PH_W_DIGIT, PH_H_DIGIT: begin
            if (is_num) begin
               acc_in = acc_sat;
               if (acc_big) begin
                  ovf_in = 1'b1;
               end
            end else begin
               // Value ends; a blank or hash byte is the first of the next skip, any other byte goes to the next start.
               if (cur_phase == PH_W_DIGIT) begin
                  w_in = cur_acc;
               end else begin
                  h_in = cur_acc;
               end
               line_in = 1'b1;
               cmt_in  = 1'b0;
               if (is_hash) begin
                  cmt_in   = 1'b1;
                  phase_in = cur_phase + 4'd1;
               end else if (is_blank) begin
                  line_in  = is_lf;
                  phase_in = cur_phase + 4'd1;
               end else begin
                  phase_in = cur_phase + 4'd2;
               end
            end
         end
         PH_M_DIGIT: begin
            if (is_num) begin
               acc_in = acc_sat;
            end else if (cur_acc != DIM_BITS'(MAXVAL_REQ)) begin
               st_vld  = 1'b1;
               st_code = ST_BAD_MAXVAL;
            end else if (is_lf) begin
               st_vld  = 1'b1;
               st_code = cur_ovf ? ST_OVERFLOW : ST_OK;
               hlen    = count_inc;
            end else begin
               phase_in = PH_SEEK_LF;
            end
         end
         PH_SEEK_LF: begin
            if (is_lf) begin
               st_vld  = 1'b1;
               st_code = cur_ovf ? ST_OVERFLOW : ST_OK;
               hlen    = count_inc;
            end
         end
         default: begin
            // Header already reported: bytes are dropped until a restart.
         end
      endcase

      // Out of data or at the byte limit with nothing decided.
      if (active && !st_vld && (item.last_byte || (count_inc >= max_bytes))) begin
         st_vld  = 1'b1;
         st_code = ST_TRUNCATED;
      end

      if (active && st_vld) begin
         phase_in = PH_DONE;
      end
   end

   // Result word assembly; bad magic clears the descriptive fields.
   always_comb begin
      result.status          = st_code;
      result.header_len      = hlen;
      if (st_code == ST_BAD_MAGIC) begin
         result.width           = '0;
         result.height          = '0;
         result.bytes_per_pixel = '0;
      end else begin
         result.width           = FIELD_W'(w_in);
         result.height          = FIELD_W'(h_in);
         result.bytes_per_pixel = bpp_in;
      end
   end

   // Bytes that raise a result wait for room in the output register.
   assign emit    = item_valid & active & st_vld & (~st_vld | out_ready) & advance;
   assign advance = item_valid & (~(active & st_vld) | out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC_P;
         count_ff <= '0;
         acc_ff   <= '0;
         line_ff  <= 1'b1;
         cmt_ff   <= 1'b0;
         w_ff     <= '0;
         h_ff     <= '0;
         bpp_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
         line_ff  <= line_in;
         cmt_ff   <= cmt_in;
         w_ff     <= w_in;
         h_ff     <= h_in;
         bpp_ff   <= bpp_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

@@ rtl/core/ppmhp_out_stage.sv @@
// Result register that holds one word until the consumer takes it.
module ppmhp_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  ppmhp_pkg::rsp_item_type load_item,
   output logic                    out_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ppmhp_pkg::rsp_item_type rsp_item
);
   import ppmhp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   // Room when empty or when the held word leaves this cycle.
   assign out_ready = ~valid_ff | ~rsp_stall;
   assign valid_in  = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

@@ rtl/core/ppm_header_parser_unit.sv @@
// PPM/PGM header parser: one file byte per word, one result word per file.
// Path: an accepted byte is held in the input register and parsed there, and a result it
// raises is loaded into the result register that drives rsp_.
// Throughput: one byte per cycle while no result byte waits on a stalled result register,
// set by the combinational parse logic between the input and result registers.
// Reset (synchronous): parser waits for byte 0 of a file, both registers empty,
// max_header_bytes returns to 256.
module ppm_header_parser_unit #(
   parameter int DIM_BITS = ppmhp_pkg::DIM_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ppmhp_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                               req_first_byte,
   input  logic                               req_last_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ppmhp_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ppmhp_pkg::FIELD_W-1:0]      rsp_width,
   output logic [ppmhp_pkg::FIELD_W-1:0]      rsp_height,
   output logic [ppmhp_pkg::BPP_W-1:0]        rsp_bytes_per_pixel,
   output logic [ppmhp_pkg::COUNT_W-1:0]      rsp_header_len,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ppmhp_pkg::COUNT_W-1:0]      csr_wdata
);
   import ppmhp_pkg::*;

   req_item_type       req_item, item;
   rsp_item_type       result, rsp_item;
   logic               item_valid, advance, emit, out_ready;
   logic [COUNT_W-1:0] max_hdr_ff;

   // Header byte limit register; always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_hdr_ff <= MAX_HDR_RESET;
      end else if (csr_valid && csr_ready) begin
         max_hdr_ff <= csr_wdata;
      end
   end

   assign req_item.data_byte  = req_data_byte;
   assign req_item.first_byte = req_first_byte;
   assign req_item.last_byte  = req_last_byte;

   ppmhp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ppmhp_parse #(
      .DIM_BITS (DIM_BITS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_ready  (out_ready),
      .max_bytes  (max_hdr_ff),
      .advance    (advance),
      .emit       (emit),
      .result     (result)
   );

   ppmhp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_item (result),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_status          = rsp_item.status;
   assign rsp_width           = rsp_item.width;
   assign rsp_height          = rsp_item.height;
   assign rsp_bytes_per_pixel = rsp_item.bytes_per_pixel;
   assign rsp_header_len      = rsp_item.header_len;

   // The result register comes out of reset empty.
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present right after reset");

   // Bad magic reports no dimensions and no pixel size.
   a_magic_clear : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_BAD_MAGIC) |->
      (rsp_width == '0 && rsp_height == '0 && rsp_bytes_per_pixel == '0))
      else $error("bad magic result carries fields");

   // Only a completed header carries a length.
   a_len_only_done : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK && rsp_status != ST_OVERFLOW) |->
      (rsp_header_len == '0))
      else $error("header length on an unfinished header");

   // A completed header always has a known pixel size.
   a_bpp_known : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_OK || rsp_status == ST_OVERFLOW)) |->
      (rsp_bytes_per_pixel == BPP_GRAY || rsp_bytes_per_pixel == BPP_RGB))
      else $error("completed header without pixel size");

endmodule
